// ===== rtl/lsca_pkg.sv =====
// lsca_pkg: shared codes, field widths and channel layout for the led strip color animator
// no dependencies; imported by led_strip_color_animator, lsca_checker and testbench

package lsca_pkg;

   // payload widths fixed by the port list
   localparam int unsigned ChanW   = 8;
   localparam int unsigned IdxW    = 4;
   localparam int unsigned NumChan = 3;

   // channel slots in the per-channel arrays
   localparam int unsigned ChRed   = 0;
   localparam int unsigned ChGreen = 1;
   localparam int unsigned ChBlue  = 2;

   // operation codes
   localparam logic OpStart   = 1'b0;
   localparam logic OpAdvance = 1'b1;

   // animation kinds
   localparam logic ModeSlide = 1'b0;
   localparam logic ModeFade  = 1'b1;

   // slide order
   localparam logic DirDown = 1'b0;
   localparam logic DirUp   = 1'b1;

   typedef logic [ChanW-1:0] chan_type;

endpackage

// ===== rtl/led_strip_color_animator.sv =====
// led_strip_color_animator: linear color fade over an led strip, fade or slide mode
// depends on lsca_pkg for codes, widths and the channel type
//
//   channel | ports        | direction | beat
//   --------+--------------+-----------+------------------------------------------
//   request | req_*        | in        | start (target, mode, direction) or advance
//   response| rsp_*        | out       | one pixel write with frame_end / finished
//
// four-stage pipe: request register, j*|to-from|, reciprocal multiply, correction
// and output register. a frame's first write runs through every register of the pipe.
// a fade frame sends NUM_PIXELS writes on the single response port and holds the pipe
// until its last write is taken; starts and slide advances one per cycle when not held.
// reset is synchronous and leaves the strip color black and the block idle.
// rsp_ready low holds the output write and backs up the pipe stage by stage.

module led_strip_color_animator
   import lsca_pkg::*;
#(
   parameter int unsigned NUM_PIXELS = 13,
   parameter int unsigned RAMP_STEPS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_operation,
   input  logic             req_mode,
   input  logic             req_direction,
   input  logic [ChanW-1:0] req_to_red,
   input  logic [ChanW-1:0] req_to_green,
   input  logic [ChanW-1:0] req_to_blue,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [IdxW-1:0]  rsp_pixel_index,
   output logic [ChanW-1:0] rsp_red,
   output logic [ChanW-1:0] rsp_green,
   output logic [ChanW-1:0] rsp_blue,
   output logic             rsp_frame_end,
   output logic             rsp_finished
);

   localparam int unsigned PixW    = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
   localparam int unsigned StepW   = $clog2(RAMP_STEPS);
   localparam int unsigned Divisor = RAMP_STEPS - 1;
   localparam int unsigned ProdW   = StepW + ChanW;
   localparam int unsigned RecipS  = ProdW;
   localparam int unsigned RecipM  = (2 ** RecipS) / Divisor;
   localparam int unsigned RecipW  = RecipS + 1;
   localparam int unsigned WideW   = ProdW + RecipW;

   localparam logic [PixW-1:0]  LastPix  = PixW'(NUM_PIXELS - 1);
   localparam logic [StepW-1:0] LastStep = StepW'(RAMP_STEPS - 1);

   typedef struct packed {
      logic            fade;
      logic            final_frame;
      logic [PixW-1:0] pix;
   } ctl_type;

   // animation state
   chan_type         cur_ff [NumChan];
   chan_type         cur_in [NumChan];
   chan_type         tgt_ff [NumChan];
   chan_type         tgt_in [NumChan];
   logic             mode_ff, mode_in;
   logic             dir_ff, dir_in;
   logic             busy_ff, busy_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [PixW-1:0]  pix_ff, pix_in;

   // pipe stages
   logic             s1_v_ff, s2_v_ff, s3_v_ff;
   ctl_type          s1_ctl_ff, s2_ctl_ff, s3_ctl_ff;
   logic [StepW-1:0] s1_j_ff;
   chan_type         s1_from_ff [NumChan];
   chan_type         s1_to_ff [NumChan];
   chan_type         s2_from_ff [NumChan];
   logic             s2_neg_ff [NumChan];
   logic [ProdW-1:0] s2_p_ff [NumChan];
   chan_type         s3_from_ff [NumChan];
   logic             s3_neg_ff [NumChan];
   logic [ProdW-1:0] s3_p_ff [NumChan];
   chan_type         s3_q0_ff [NumChan];

   // output register
   logic             rsp_valid_ff;
   logic [PixW-1:0]  rsp_idx_ff;
   chan_type         rsp_color_ff [NumChan];
   logic             rsp_frame_end_ff;
   logic             rsp_finished_ff;
   logic             rsp_final_ff;

   // combinational
   logic             req_fire, is_adv, job_fire, last_step, slide_fin;
   logic             out_free, s3_free, s2_free, s1_free;
   logic             s1_move, s2_move, s3_move;
   logic             s1_neg [NumChan];
   logic [ProdW-1:0] s1_p [NumChan];
   chan_type         s2_q0 [NumChan];
   chan_type         s3_val [NumChan];
   ctl_type          job_ctl;
   logic [PixW-1:0]  slide_pix;
   logic [PixW-1:0]  idx_next;
   logic [PixW+IdxW-1:0] idx_wide;

   // handshake and flow through the pipe
   assign out_free  = !rsp_valid_ff || (rsp_ready && rsp_frame_end_ff);
   assign s3_free   = !s3_v_ff || out_free;
   assign s2_free   = !s2_v_ff || s3_free;
   assign s1_free   = !s1_v_ff || s2_free;
   assign s3_move   = s3_v_ff && out_free;
   assign s2_move   = s2_v_ff && s3_free;
   assign s1_move   = s1_v_ff && s2_free;
   assign req_ready = s1_free;

   assign req_fire  = req_valid && req_ready;
   assign is_adv    = (req_operation == OpAdvance);
   assign job_fire  = req_fire && is_adv && busy_ff;
   assign last_step = (step_ff == LastStep);
   assign slide_fin = last_step && (pix_ff == LastPix);
   assign slide_pix = (dir_ff == DirUp) ? pix_ff : LastPix - pix_ff;

   always_comb begin
      job_ctl.fade        = (mode_ff == ModeFade);
      job_ctl.final_frame = (mode_ff == ModeFade) ? last_step : slide_fin;
      job_ctl.pix         = slide_pix;
   end

   // animation state update
   always_comb begin
      cur_in  = cur_ff;
      tgt_in  = tgt_ff;
      mode_in = mode_ff;
      dir_in  = dir_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      pix_in  = pix_ff;
      if (req_fire && !is_adv && !busy_ff) begin
         mode_in         = req_mode;
         dir_in          = req_direction;
         tgt_in[ChRed]   = req_to_red;
         tgt_in[ChGreen] = req_to_green;
         tgt_in[ChBlue]  = req_to_blue;
         step_in         = '0;
         pix_in          = '0;
         busy_in         = 1'b1;
      end else if (job_fire) begin
         if (!last_step) begin
            step_in = step_ff + StepW'(1);
         end else begin
            step_in = '0;
            if (mode_ff == ModeFade || slide_fin) begin
               cur_in  = tgt_ff;
               busy_in = 1'b0;
               pix_in  = '0;
            end else begin
               pix_in = pix_ff + PixW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NumChan; c++) begin
            cur_ff[c] <= '0;
            tgt_ff[c] <= '0;
         end
         mode_ff <= ModeSlide;
         dir_ff  <= DirDown;
         busy_ff <= 1'b0;
         step_ff <= '0;
         pix_ff  <= '0;
      end else begin
         cur_ff  <= cur_in;
         tgt_ff  <= tgt_in;
         mode_ff <= mode_in;
         dir_ff  <= dir_in;
         busy_ff <= busy_in;
         step_ff <= step_in;
         pix_ff  <= pix_in;
      end
   end

   // stage 1 math: sign and j * |to - from|
   always_comb begin
      for (int c = 0; c < NumChan; c++) begin
         s1_neg[c] = (s1_to_ff[c] < s1_from_ff[c]);
         s1_p[c]   = ProdW'(s1_j_ff) *
                     ProdW'(s1_neg[c] ? s1_from_ff[c] - s1_to_ff[c]
                                      : s1_to_ff[c] - s1_from_ff[c]);
      end
   end

   // stage 2 math: reciprocal estimate of p / (RAMP_STEPS-1), low by at most one
   always_comb begin
      logic [WideW-1:0] wide;
      for (int c = 0; c < NumChan; c++) begin
         wide     = WideW'(s2_p_ff[c]) * WideW'(RecipM);
         s2_q0[c] = wide[RecipS +: ChanW];
      end
   end

   // stage 3 math: remainder correction and apply the signed step
   always_comb begin
      logic [ProdW-1:0] rem;
      chan_type         q;
      for (int c = 0; c < NumChan; c++) begin
         rem       = s3_p_ff[c] - ProdW'(s3_q0_ff[c]) * ProdW'(Divisor);
         q         = s3_q0_ff[c] + ChanW'(rem >= ProdW'(Divisor));
         s3_val[c] = s3_neg_ff[c] ? s3_from_ff[c] - q : s3_from_ff[c] + q;
      end
   end

   // pipe valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (s1_free) s1_v_ff <= job_fire;
         if (s2_free) s2_v_ff <= s1_v_ff;
         if (s3_free) s3_v_ff <= s2_v_ff;
      end
   end

   // pipe payload
   always_ff @(posedge clock) begin
      if (job_fire) begin
         s1_ctl_ff  <= job_ctl;
         s1_j_ff    <= step_ff;
         s1_from_ff <= cur_ff;
         s1_to_ff   <= tgt_ff;
      end
      if (s1_move) begin
         s2_ctl_ff  <= s1_ctl_ff;
         s2_from_ff <= s1_from_ff;
         s2_neg_ff  <= s1_neg;
         s2_p_ff    <= s1_p;
      end
      if (s2_move) begin
         s3_ctl_ff  <= s2_ctl_ff;
         s3_from_ff <= s2_from_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_p_ff    <= s2_p_ff;
         s3_q0_ff   <= s2_q0;
      end
   end

   // output register: one beat per slide frame, NUM_PIXELS beats per fade frame
   assign idx_next = rsp_idx_ff + PixW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_move) begin
         rsp_color_ff     <= s3_val;
         rsp_final_ff     <= s3_ctl_ff.final_frame;
         rsp_idx_ff       <= s3_ctl_ff.fade ? '0 : s3_ctl_ff.pix;
         rsp_frame_end_ff <= s3_ctl_ff.fade ? (LastPix == '0) : 1'b1;
         rsp_finished_ff  <= s3_ctl_ff.final_frame &&
                             (s3_ctl_ff.fade ? (LastPix == '0) : 1'b1);
      end else if (rsp_valid_ff && rsp_ready && !rsp_frame_end_ff) begin
         rsp_idx_ff       <= idx_next;
         rsp_frame_end_ff <= (idx_next == LastPix);
         rsp_finished_ff  <= rsp_final_ff && (idx_next == LastPix);
      end
   end

   assign idx_wide        = {{IdxW{1'b0}}, rsp_idx_ff};
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = idx_wide[IdxW-1:0];
   assign rsp_red         = rsp_color_ff[ChRed];
   assign rsp_green       = rsp_color_ff[ChGreen];
   assign rsp_blue        = rsp_color_ff[ChBlue];
   assign rsp_frame_end   = rsp_frame_end_ff;
   assign rsp_finished    = rsp_finished_ff;

`ifndef SYNTH
   // a stalled request side always traces back to a held output write
   a_stall_has_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff)
      else $error("request stalled with empty output register");

   // finished only ever rides on the last write of a frame
   a_finished_on_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_finished_ff |-> rsp_frame_end_ff)
      else $error("finished without frame_end");

   // written pixel stays on the strip
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_idx_ff <= LastPix)
      else $error("pixel index beyond strip");

   // within a fade frame the pixel index walks up by one per beat
   a_fade_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !rsp_frame_end_ff
      |=> rsp_valid_ff && rsp_idx_ff == $past(rsp_idx_ff) + PixW'(1))
      else $error("fade frame index did not advance");

   // animation ends only on an accepted advance
   a_busy_falls_on_advance: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(req_valid && req_ready && req_operation == OpAdvance))
      else $error("busy cleared without an advance");
`endif

endmodule

// ===== test/lsca_checker.sv =====
// lsca_checker: watches both channels of the led strip color animator, predicts every pixel write
// depends on lsca_pkg for codes, widths and the channel type; instantiated by testbench
`timescale 1ns / 1ps

module lsca_checker
   import lsca_pkg::*;
#(
   parameter int unsigned NUM_PIXELS = 13,
   parameter int unsigned RAMP_STEPS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_operation,
   input  logic             req_mode,
   input  logic             req_direction,
   input  logic [ChanW-1:0] req_to_red,
   input  logic [ChanW-1:0] req_to_green,
   input  logic [ChanW-1:0] req_to_blue,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [IdxW-1:0]  rsp_pixel_index,
   input  logic [ChanW-1:0] rsp_red,
   input  logic [ChanW-1:0] rsp_green,
   input  logic [ChanW-1:0] rsp_blue,
   input  logic             rsp_frame_end,
   input  logic             rsp_finished,
   output int unsigned      mismatch_count,
   output int unsigned      writes_due
);

   typedef struct packed {
      logic [IdxW-1:0] pixel;
      chan_type        red;
      chan_type        green;
      chan_type        blue;
      logic            frame_end;
      logic            finished;
   } pixel_write_type;

   // pixel writes still owed by the block, oldest first
   pixel_write_type due_writes[$];

   // shadow of the animation state
   logic [NumChan*ChanW-1:0] strip_color;
   logic [NumChan*ChanW-1:0] goal_color;
   logic                     fade_mode;
   logic                     walk_up;
   logic                     animating;
   int unsigned              ramp_step;
   int unsigned              pixel_pos;

   // one channel at a ramp step, signed division truncating toward zero
   function automatic chan_type ramp_level(chan_type from, chan_type to, int unsigned step);
      int span;
      int level;
      span  = int'(to) - int'(from);
      level = int'(from) + (int'(step) * span) / (int'(RAMP_STEPS) - 1);
      return level[ChanW-1:0];
   endfunction

   function automatic pixel_write_type make_write(int unsigned pixel, logic fend, logic fin);
      pixel_write_type w;
      w.pixel     = pixel[IdxW-1:0];
      w.red       = ramp_level(strip_color[2*ChanW +: ChanW], goal_color[2*ChanW +: ChanW],
                               ramp_step);
      w.green     = ramp_level(strip_color[ChanW +: ChanW], goal_color[ChanW +: ChanW],
                               ramp_step);
      w.blue      = ramp_level(strip_color[0 +: ChanW], goal_color[0 +: ChanW], ramp_step);
      w.frame_end = fend;
      w.finished  = fin;
      return w;
   endfunction

   // advance the shadow state by one request beat and queue the writes it causes
   task automatic take_request(logic op, logic mode, logic dir, chan_type r, chan_type g,
                               chan_type b);
      logic        last_step;
      logic        fin;
      int unsigned pix;
      if (op == OpStart) begin
         // a start while busy changes nothing
         if (!animating) begin
            fade_mode  = mode;
            walk_up    = dir;
            goal_color = {r, g, b};
            ramp_step  = 0;
            pixel_pos  = 0;
            animating  = 1'b1;
         end
      end else if (animating) begin
         last_step = (ramp_step == RAMP_STEPS - 1);
         if (fade_mode == ModeFade) begin
            // whole strip at the same step, pixels 0 upward
            for (int i = 0; i < NUM_PIXELS; i++) begin
               due_writes.push_back(make_write(i, i == NUM_PIXELS - 1,
                                               i == NUM_PIXELS - 1 && last_step));
            end
            if (last_step) begin
               strip_color = goal_color;
               animating   = 1'b0;
               ramp_step   = 0;
            end else begin
               ramp_step++;
            end
         end else begin
            // one pixel ramps at a time, walking in the latched order
            pix = (walk_up == DirUp) ? pixel_pos : NUM_PIXELS - 1 - pixel_pos;
            fin = last_step && (pixel_pos == NUM_PIXELS - 1);
            due_writes.push_back(make_write(pix, 1'b1, fin));
            if (last_step) begin
               ramp_step = 0;
               if (fin) begin
                  strip_color = goal_color;
                  animating   = 1'b0;
                  pixel_pos   = 0;
               end else begin
                  pixel_pos++;
               end
            end else begin
               ramp_step++;
            end
         end
      end
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // compare one response beat with the oldest owed write
   task automatic check_write();
      pixel_write_type want;
      if (due_writes.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected write, expected none, actual pixel %0d rgb %0d %0d %0d",
                  $time, rsp_pixel_index, rsp_red, rsp_green, rsp_blue);
      end else begin
         want = due_writes.pop_front();
         check_field("pixel_index", want.pixel, rsp_pixel_index);
         check_field("red", want.red, rsp_red);
         check_field("green", want.green, rsp_green);
         check_field("blue", want.blue, rsp_blue);
         check_field("frame_end", want.frame_end, rsp_frame_end);
         check_field("finished", want.finished, rsp_finished);
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         due_writes.delete();
         strip_color = '0;
         goal_color  = '0;
         fade_mode   = ModeSlide;
         walk_up     = DirDown;
         animating   = 1'b0;
         ramp_step   = 0;
         pixel_pos   = 0;
      end else begin
         if (req_valid && req_ready) begin
            take_request(req_operation, req_mode, req_direction, req_to_red, req_to_green,
                         req_to_blue);
         end
         if (rsp_valid && rsp_ready) begin
            check_write();
         end
      end
      writes_due = due_writes.size();
   end

endmodule

// ===== test/testbench.sv =====
// testbench: drives start and advance beats into led_strip_color_animator and gives the verdict
// depends on lsca_pkg, led_strip_color_animator and lsca_checker
`timescale 1ns / 1ps

module testbench;
   import lsca_pkg::*;

   localparam int unsigned StripLen    = 13;
   localparam int unsigned RampLen     = 256;
   localparam int unsigned RandomBeats = 40;
   localparam int unsigned CalmBeats   = 15;
   localparam int unsigned QuietLimit  = 2000;
   localparam int unsigned DrainCycles = 20;

   logic             clock         = 1'b0;
   logic             reset         = 1'b1;
   logic             req_valid     = 1'b0;
   logic             req_ready;
   logic             req_operation = OpStart;
   logic             req_mode      = ModeSlide;
   logic             req_direction = DirDown;
   logic [ChanW-1:0] req_to_red    = '0;
   logic [ChanW-1:0] req_to_green  = '0;
   logic [ChanW-1:0] req_to_blue   = '0;
   logic             rsp_valid;
   logic             rsp_ready     = 1'b1;
   logic [IdxW-1:0]  rsp_pixel_index;
   logic [ChanW-1:0] rsp_red;
   logic [ChanW-1:0] rsp_green;
   logic [ChanW-1:0] rsp_blue;
   logic             rsp_frame_end;
   logic             rsp_finished;

   int unsigned mismatch_count;
   int unsigned writes_due;
   int unsigned gap_pct     = 0;
   int unsigned stall_pct   = 0;
   int unsigned stall_left  = 0;
   int unsigned quiet_count = 0;

   always #6 clock = ~clock;

   led_strip_color_animator #(
      .NUM_PIXELS(StripLen),
      .RAMP_STEPS(RampLen)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_mode       (req_mode),
      .req_direction  (req_direction),
      .req_to_red     (req_to_red),
      .req_to_green   (req_to_green),
      .req_to_blue    (req_to_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_index(rsp_pixel_index),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_finished   (rsp_finished)
   );

   lsca_checker #(
      .NUM_PIXELS(StripLen),
      .RAMP_STEPS(RampLen)
   ) check_unit (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_mode       (req_mode),
      .req_direction  (req_direction),
      .req_to_red     (req_to_red),
      .req_to_green   (req_to_green),
      .req_to_blue    (req_to_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_index(rsp_pixel_index),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_finished   (rsp_finished),
      .mismatch_count (mismatch_count),
      .writes_due     (writes_due)
   );

   // response back-pressure in bursts of random length, started at stall_pct odds
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < stall_pct) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_count <= 0;
      end else if (quiet_count == QuietLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // new idling odds for both sides, zero one time in three
   task automatic pick_pace();
      gap_pct   = 15 * $urandom_range(2);
      stall_pct = 15 * $urandom_range(2);
   endtask

   // one request beat, entered and left at a falling edge
   task automatic send_beat(logic op, logic mode, logic dir, logic [ChanW-1:0] r,
                            logic [ChanW-1:0] g, logic [ChanW-1:0] b);
      int unsigned gap;
      if ($urandom_range(99) < gap_pct) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation <= op;
      req_mode      <= mode;
      req_direction <= dir;
      req_to_red    <= r;
      req_to_green  <= g;
      req_to_blue   <= b;
      req_valid     <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // advance beat, its unused fields filled at random
   task automatic send_advance();
      send_beat(OpAdvance, 1'($urandom_range(1)), 1'($urandom_range(1)),
                8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   // start plus a run of advances, with the odd start thrown in while busy
   task automatic run_animation(logic mode, logic dir, logic [ChanW-1:0] r,
                                logic [ChanW-1:0] g, logic [ChanW-1:0] b,
                                int unsigned frames);
      send_beat(OpStart, mode, dir, r, g, b);
      for (int f = 0; f < frames; f++) begin
         if (f % 64 == 0) pick_pace();
         if ($urandom_range(99) < 3) begin
            send_beat(OpStart, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
         end
         send_advance();
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // advance with nothing running is dropped
      send_advance();

      // one full fade from black, through the last step and the finished flag
      run_animation(ModeFade, DirUp, 8'hFF, 8'h00, 8'hFF, RampLen);

      // random mix of starts and advances from the faded color, no idling at the tail
      for (int n = 0; n < RandomBeats; n++) begin
         if (n % 50 == 0) pick_pace();
         if (n >= RandomBeats - CalmBeats) begin
            gap_pct   = 0;
            stall_pct = 0;
         end
         send_beat(($urandom_range(99) < 80) ? OpAdvance : OpStart, 1'($urandom_range(1)),
                   1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
      end
      req_valid <= 1'b0;

      // drain the owed writes, then give stray writes a chance to show
      while (writes_due != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
